/* rtl/sfs_pkg.sv */
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared constants, codes and reset values of the sprite frame sequencer.
// ----------------------------------------------------------------------------
package sfs_pkg;

    // parameter defaults
    localparam int CLIP_DEPTH_DEF = 16;
    localparam int FRAME_BITS_DEF = 10;
    localparam int TIME_BITS_DEF  = 24;

    // fixed field widths
    localparam int FUNC_W      = 2;
    localparam int ENTRY_IDX_W = 4;
    localparam int CLIP_LEN_W  = 5;
    localparam int SHEET_W     = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int OP_W        = 2;

    // words held between the front and the back
    localparam int QUEUE_DEPTH = 4;

    // input function codes
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

    // classified operations
    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_TICK    = 2'd0;
    localparam t_op OP_LOAD    = 2'd1;
    localparam t_op OP_RESTART = 2'd2;
    localparam t_op OP_NOP     = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_USE_CLIP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_DURATION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_FRAME    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_FRAME      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LENGTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SHEET_COLUMNS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SHEET_ROWS     = 3'd7;

    // configuration reset values
    localparam logic                  RST_USE_CLIP    = 1'b0;
    localparam logic                  RST_LOOP_ENABLE = 1'b1;
    localparam int                    RST_DURATION    = 6554;
    localparam logic [CLIP_LEN_W-1:0] RST_CLIP_LENGTH = 5'd1;
    localparam logic [SHEET_W-1:0]    RST_SHEET_SIZE  = 11'd1;

endpackage

/* rtl/sfs_front.sv */
// ----------------------------------------------------------------------------
// sfs_front
// Accepts input words, classifies the function code and pushes one command
// word per item into the queue.
// ----------------------------------------------------------------------------
module sfs_front #(
    parameter int CLIP_DEPTH = sfs_pkg::CLIP_DEPTH_DEF,
    parameter int FRAME_BITS = sfs_pkg::FRAME_BITS_DEF,
    parameter int TIME_BITS  = sfs_pkg::TIME_BITS_DEF
) (
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [sfs_pkg::FUNC_W-1:0]         i_func,
    input  logic [TIME_BITS-1:0]               i_tick_time,
    input  logic [sfs_pkg::ENTRY_IDX_W-1:0]    i_entry_index,
    input  logic [FRAME_BITS-1:0]              i_entry_frame,
    input  logic                               i_full,
    output logic                               o_push,
    output logic [sfs_pkg::OP_W+TIME_BITS+sfs_pkg::ENTRY_IDX_W+FRAME_BITS-1:0] o_word
);
    import sfs_pkg::*;

    t_op op;

    always_comb begin
        case (i_func)
            FUNC_TICK:    op = OP_TICK;
            FUNC_LOAD:    op = (32'(i_entry_index) < CLIP_DEPTH) ? OP_LOAD : OP_NOP;
            FUNC_RESTART: op = OP_RESTART;
            default:      op = OP_NOP;
        endcase
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign o_word  = {op, i_tick_time, i_entry_index, i_entry_frame};

endmodule

/* rtl/sfs_queue.sv */
// ----------------------------------------------------------------------------
// sfs_queue
// Short first-in first-out queue of command words between front and back.
// ----------------------------------------------------------------------------
module sfs_queue #(
    parameter int DATA_W = 40
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);
    import sfs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == FULL);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/sfs_div.sv */
// ----------------------------------------------------------------------------
// sfs_div
// Restoring divider, one quotient bit per cycle: frame over column count.
// ----------------------------------------------------------------------------
module sfs_div #(
    parameter int FRAME_BITS = sfs_pkg::FRAME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [FRAME_BITS-1:0]          i_dividend,
    input  logic [sfs_pkg::SHEET_W-1:0]    i_divisor,
    output logic                           o_done,
    output logic [FRAME_BITS-1:0]          o_quot,
    output logic [sfs_pkg::SHEET_W-1:0]    o_rem
);
    import sfs_pkg::*;

    localparam int CNT_W = $clog2(FRAME_BITS + 1);
    localparam int REM_W = SHEET_W + 1;

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [SHEET_W-1:0]    r_rem;
    logic [FRAME_BITS-1:0] r_quot;
    logic [SHEET_W-1:0]    r_div;
    logic [REM_W-1:0]      trial;
    logic [REM_W-1:0]      diff;
    logic                  ge;

    // remainder stays below the divisor, so the trial fits one extra bit
    assign trial = {r_rem, r_quot[FRAME_BITS-1]};
    assign ge    = (trial >= {1'b0, r_div});
    assign diff  = ge ? (trial - {1'b0, r_div}) : trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FRAME_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= diff[SHEET_W-1:0];
            r_quot <= {r_quot[FRAME_BITS-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

/* rtl/sfs_back.sv */
// ----------------------------------------------------------------------------
// sfs_back
// Carries out queued commands: time accumulation, frame stepping, clip table,
// tile position through the divider, and the result register.
// ----------------------------------------------------------------------------
module sfs_back #(
    parameter int CLIP_DEPTH = sfs_pkg::CLIP_DEPTH_DEF,
    parameter int FRAME_BITS = sfs_pkg::FRAME_BITS_DEF,
    parameter int TIME_BITS  = sfs_pkg::TIME_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_valid,
    input  logic [sfs_pkg::OP_W+TIME_BITS+sfs_pkg::ENTRY_IDX_W+FRAME_BITS-1:0] i_q_data,
    output logic                             o_pop,
    input  logic                             i_use_clip,
    input  logic                             i_loop_enable,
    input  logic [TIME_BITS-1:0]             i_frame_duration,
    input  logic [FRAME_BITS-1:0]            i_start_frame,
    input  logic [FRAME_BITS-1:0]            i_end_frame,
    input  logic [sfs_pkg::CLIP_LEN_W-1:0]   i_clip_length,
    input  logic [sfs_pkg::SHEET_W-1:0]      i_sheet_columns,
    input  logic [sfs_pkg::SHEET_W-1:0]      i_sheet_rows,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [FRAME_BITS-1:0]            o_frame_index,
    output logic [FRAME_BITS-1:0]            o_tile_column,
    output logic [FRAME_BITS-1:0]            o_tile_row_flipped,
    output logic                             o_outside_sheet,
    output logic                             o_frame_advanced
);
    import sfs_pkg::*;

    localparam int WORD_W = OP_W + TIME_BITS + ENTRY_IDX_W + FRAME_BITS;
    localparam int POS_W  = (CLIP_DEPTH > 1) ? $clog2(CLIP_DEPTH) : 1;
    localparam int LEN_W  = (POS_W + 1 > CLIP_LEN_W) ? POS_W + 1 : CLIP_LEN_W;
    localparam int EL_W   = TIME_BITS + 1;
    localparam int ROW_W  = (FRAME_BITS > SHEET_W) ? FRAME_BITS : SHEET_W;

    localparam logic [EL_W-1:0]       EL_MAX    = '1;
    localparam logic [LEN_W-1:0]      DEPTH_L   = LEN_W'(CLIP_DEPTH);
    localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_STEP  = 3'd1;
    localparam logic [2:0] S_MEM   = 3'd2;
    localparam logic [2:0] S_DIVGO = 3'd3;
    localparam logic [2:0] S_DIVW  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]            r_state;
    logic [EL_W-1:0]       r_elapsed;
    logic [FRAME_BITS-1:0] r_frame;
    logic [POS_W-1:0]      r_pos;
    logic                  r_adv;
    logic [FRAME_BITS-1:0] r_col;
    logic [FRAME_BITS-1:0] r_flip;
    logic                  r_outside;
    logic [FRAME_BITS-1:0] r_clip [CLIP_DEPTH];
    logic [FRAME_BITS-1:0] r_mem_q;

    t_op                    q_op;
    logic [TIME_BITS-1:0]   q_time;
    logic [ENTRY_IDX_W-1:0] q_idx;
    logic [FRAME_BITS-1:0]  q_frame;

    logic [EL_W:0]         sum;
    logic [EL_W-1:0]       sum_sat;
    logic [EL_W-1:0]       dur_ext;
    logic                  reached;
    logic [LEN_W-1:0]      clen;
    logic [LEN_W-1:0]      len_eff;
    logic [LEN_W-1:0]      pos_inc;
    logic [LEN_W-1:0]      pos_next;
    logic [FRAME_BITS:0]   frame_inc;
    logic [FRAME_BITS-1:0] frame_next;
    logic [POS_W-1:0]      rd_addr;
    logic                  mem_we;
    logic                  take;

    logic [SHEET_W-1:0]    divisor;
    logic                  div_done;
    logic [FRAME_BITS-1:0] div_quot;
    logic [SHEET_W-1:0]    div_rem;
    logic [ROW_W-1:0]      row_e;
    logic [ROW_W-1:0]      rows_e;
    logic [ROW_W-1:0]      flip_e;

    assign q_op    = i_q_data[WORD_W-1 -: OP_W];
    assign q_time  = i_q_data[FRAME_BITS+ENTRY_IDX_W +: TIME_BITS];
    assign q_idx   = i_q_data[FRAME_BITS +: ENTRY_IDX_W];
    assign q_frame = i_q_data[FRAME_BITS-1:0];

    assign o_pop = (r_state == S_IDLE);
    assign take  = o_pop && i_q_valid;

    // saturating accumulate of the tick time
    assign sum     = {1'b0, r_elapsed} + (EL_W + 1)'(q_time);
    assign sum_sat = sum[EL_W] ? EL_MAX : sum[EL_W-1:0];
    assign dur_ext = EL_W'(i_frame_duration);
    assign reached = (r_elapsed >= dur_ext);

    // clip position step, wrap or clamp at the end of the clip
    always_comb begin
        clen = LEN_W'(i_clip_length);
        if (clen == '0) begin
            len_eff = LEN_W'(1);
        end else if (clen > DEPTH_L) begin
            len_eff = DEPTH_L;
        end else begin
            len_eff = clen;
        end
        pos_inc = LEN_W'(r_pos) + LEN_W'(1);
        if (pos_inc >= len_eff) begin
            pos_next = i_loop_enable ? '0 : len_eff - LEN_W'(1);
        end else begin
            pos_next = pos_inc;
        end
    end

    // range step, wrap to start or hold the end frame
    always_comb begin
        frame_inc = {1'b0, r_frame} + (FRAME_BITS + 1)'(1);
        if (frame_inc > {1'b0, i_end_frame}) begin
            frame_next = i_loop_enable ? i_start_frame : i_end_frame;
        end else begin
            frame_next = frame_inc[FRAME_BITS-1:0];
        end
    end

    assign rd_addr = (r_state == S_STEP) ? POS_W'(pos_next) : '0;
    assign mem_we  = take && (q_op == OP_LOAD);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_clip[POS_W'(q_idx)] <= q_frame;
        end
        r_mem_q <= r_clip[rd_addr];
    end

    assign divisor = (i_sheet_columns == '0) ? SHEET_W'(1) : i_sheet_columns;

    sfs_div #(
        .FRAME_BITS (FRAME_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIVGO),
        .i_dividend (r_frame),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign row_e  = ROW_W'(div_quot);
    assign rows_e = ROW_W'(i_sheet_rows);
    assign flip_e = rows_e - ROW_W'(1) - row_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_elapsed <= '0;
            r_frame   <= '0;
            r_pos     <= '0;
            r_adv     <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_adv <= 1'b0;
                        case (q_op)
                            OP_TICK: begin
                                r_elapsed <= sum_sat;
                                r_state   <= S_STEP;
                            end
                            OP_RESTART: begin
                                r_elapsed <= '0;
                                r_pos     <= '0;
                                if (i_use_clip) begin
                                    r_state <= S_MEM;
                                end else begin
                                    r_frame <= i_start_frame;
                                    r_state <= S_DIVGO;
                                end
                            end
                            default: begin
                                r_state <= S_DIVGO;
                            end
                        endcase
                    end
                end
                S_STEP: begin
                    if (reached) begin
                        r_elapsed <= r_elapsed - dur_ext;
                        r_adv     <= 1'b1;
                        if (i_use_clip) begin
                            r_pos   <= POS_W'(pos_next);
                            r_state <= S_MEM;
                        end else begin
                            r_frame <= frame_next;
                            r_state <= S_DIVGO;
                        end
                    end else begin
                        r_state <= S_DIVGO;
                    end
                end
                S_MEM: begin
                    r_frame <= r_mem_q;
                    r_state <= S_DIVGO;
                end
                S_DIVGO: begin
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // tile position, captured when the divider finishes
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DIVW) && div_done) begin
            r_col <= FRAME_BITS'(div_rem);
            if (row_e >= rows_e) begin
                r_outside <= 1'b1;
                r_flip    <= '0;
            end else begin
                r_outside <= 1'b0;
                r_flip    <= (flip_e > ROW_W'(FRAME_MAX)) ? FRAME_MAX
                                                          : FRAME_BITS'(flip_e);
            end
        end
    end

    assign o_valid            = (r_state == S_OUT);
    assign o_frame_index      = r_frame;
    assign o_tile_column      = r_col;
    assign o_tile_row_flipped = r_flip;
    assign o_outside_sheet    = r_outside;
    assign o_frame_advanced   = r_adv;

endmodule

/* rtl/sprite_frame_sequencer_top.sv */
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_top
// Sprite sheet frame sequencer: plays a frame range or a loaded clip table
// against accumulated time and reports the frame and its tile on the sheet.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+--------------------------------------
//   input    | i_valid / o_ready       | func, tick_time, entry_index,
//            |                         | entry_frame
//   output   | o_valid / i_ready       | frame_index, tile_column,
//            |                         | tile_row_flipped, outside_sheet,
//            |                         | frame_advanced
//   config   | i_cfg_we (no wait)      | i_cfg_idx, i_cfg_data
//
// The back end takes one word at a time through step and clip read as needed,
// divider start, divider wait and output; the bit-serial column divider takes most of the time.
// The front takes words into a queue of four while the back works or waits.
// Reset is synchronous; the clip table is not cleared by it.
// A low i_ready holds the result and stalls the back; the queue then fills.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer_top #(
    parameter int CLIP_DEPTH = sfs_pkg::CLIP_DEPTH_DEF,
    parameter int FRAME_BITS = sfs_pkg::FRAME_BITS_DEF,
    parameter int TIME_BITS  = sfs_pkg::TIME_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [sfs_pkg::FUNC_W-1:0]       i_func,
    input  logic [TIME_BITS-1:0]             i_tick_time,
    input  logic [sfs_pkg::ENTRY_IDX_W-1:0]  i_entry_index,
    input  logic [FRAME_BITS-1:0]            i_entry_frame,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [FRAME_BITS-1:0]            o_frame_index,
    output logic [FRAME_BITS-1:0]            o_tile_column,
    output logic [FRAME_BITS-1:0]            o_tile_row_flipped,
    output logic                             o_outside_sheet,
    output logic                             o_frame_advanced,
    input  logic                             i_cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [((TIME_BITS > sfs_pkg::SHEET_W)
                   ? ((TIME_BITS > FRAME_BITS) ? TIME_BITS : FRAME_BITS)
                   : ((sfs_pkg::SHEET_W > FRAME_BITS) ? sfs_pkg::SHEET_W
                                                      : FRAME_BITS))-1:0] i_cfg_data
);
    import sfs_pkg::*;

    localparam int WORD_W = OP_W + TIME_BITS + ENTRY_IDX_W + FRAME_BITS;

    logic                  r_use_clip;
    logic                  r_loop_enable;
    logic [TIME_BITS-1:0]  r_frame_duration;
    logic [FRAME_BITS-1:0] r_start_frame;
    logic [FRAME_BITS-1:0] r_end_frame;
    logic [CLIP_LEN_W-1:0] r_clip_length;
    logic [SHEET_W-1:0]    r_sheet_columns;
    logic [SHEET_W-1:0]    r_sheet_rows;

    logic                  push;
    logic                  full;
    logic [WORD_W-1:0]     push_word;
    logic                  pop;
    logic                  q_valid;
    logic [WORD_W-1:0]     q_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_clip       <= RST_USE_CLIP;
            r_loop_enable    <= RST_LOOP_ENABLE;
            r_frame_duration <= TIME_BITS'(RST_DURATION);
            r_start_frame    <= '0;
            r_end_frame      <= '0;
            r_clip_length    <= RST_CLIP_LENGTH;
            r_sheet_columns  <= RST_SHEET_SIZE;
            r_sheet_rows     <= RST_SHEET_SIZE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_USE_CLIP:       r_use_clip       <= i_cfg_data[0];
                CFG_LOOP_ENABLE:    r_loop_enable    <= i_cfg_data[0];
                CFG_FRAME_DURATION: r_frame_duration <= i_cfg_data[TIME_BITS-1:0];
                CFG_START_FRAME:    r_start_frame    <= i_cfg_data[FRAME_BITS-1:0];
                CFG_END_FRAME:      r_end_frame      <= i_cfg_data[FRAME_BITS-1:0];
                CFG_CLIP_LENGTH:    r_clip_length    <= i_cfg_data[CLIP_LEN_W-1:0];
                CFG_SHEET_COLUMNS:  r_sheet_columns  <= i_cfg_data[SHEET_W-1:0];
                CFG_SHEET_ROWS:     r_sheet_rows     <= i_cfg_data[SHEET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sfs_front #(
        .CLIP_DEPTH (CLIP_DEPTH),
        .FRAME_BITS (FRAME_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_tick_time   (i_tick_time),
        .i_entry_index (i_entry_index),
        .i_entry_frame (i_entry_frame),
        .i_full        (full),
        .o_push        (push),
        .o_word        (push_word)
    );

    sfs_queue #(
        .DATA_W (WORD_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_word),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_word)
    );

    sfs_back #(
        .CLIP_DEPTH (CLIP_DEPTH),
        .FRAME_BITS (FRAME_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_q_data           (q_word),
        .o_pop              (pop),
        .i_use_clip         (r_use_clip),
        .i_loop_enable      (r_loop_enable),
        .i_frame_duration   (r_frame_duration),
        .i_start_frame      (r_start_frame),
        .i_end_frame        (r_end_frame),
        .i_clip_length      (r_clip_length),
        .i_sheet_columns    (r_sheet_columns),
        .i_sheet_rows       (r_sheet_rows),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_frame_index      (o_frame_index),
        .o_tile_column      (o_tile_column),
        .o_tile_row_flipped (o_tile_row_flipped),
        .o_outside_sheet    (o_outside_sheet),
        .o_frame_advanced   (o_frame_advanced)
    );

endmodule
